>>> hw/rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
`default_nettype none
package skt_pkg;
   localparam int CAPACITY    = 64;
   localparam int POOLS       = 4;
   localparam int KEY_BITS    = 32;
   localparam int HANDLE_BITS = 32;
   localparam int POOL_BITS   = 2;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic                 start;   // latch request, begin search
      logic                 step;    // half a binary search step: issue read or compare
      logic                 rd;      // read entry at lower bound
      logic                 shift;   // move one entry up
      logic                 write;   // write new entry at position
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic hit;
      logic full;
      logic shift_done;
      logic pool_ok;
      logic op;
   } sts_type;
endpackage
`default_nettype wire

>>> hw/rtl/skt_datapath.sv
// Datapath: entry memory, binary search, shift-insert and read data register.
`default_nettype none
module skt_datapath import skt_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic                   in_op,
   input  wire logic [POOL_BITS-1:0]   in_pool,
   input  wire logic [KEY_BITS-1:0]    in_key,
   input  wire logic [HANDLE_BITS-1:0] in_handle,
   output logic [HANDLE_BITS-1:0]      rd_handle
);
   localparam int EW = POOL_BITS + KEY_BITS + HANDLE_BITS;
   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rdata_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic op_ff;
   logic [POOL_BITS-1:0] pool_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [CNT_BITS-1:0] mid;
   logic [CNT_BITS-1:0] wptr;
   logic [IDX_BITS-1:0] raddr;
   logic rden;
   logic [POOL_BITS-1:0] e_pool;
   logic [KEY_BITS-1:0] e_key;
   logic is_lower;
   logic phase_ff, phase_in; // search step: 0 = issue read, 1 = compare

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign wptr = ptr_ff + 1'b1;
   assign e_pool = rdata_ff[EW-1 -: POOL_BITS];
   assign e_key  = rdata_ff[HANDLE_BITS +: KEY_BITS];
   assign rd_handle = rdata_ff[HANDLE_BITS-1:0];
   assign is_lower = (e_pool != pool_ff) ? (e_pool < pool_ff) : (e_key < key_ff);

   always_comb begin
      raddr = mid[IDX_BITS-1:0];
      rden  = 1'b0;
      if (cmd.step && !phase_ff) rden = 1'b1;
      if (cmd.rd) begin
         raddr = lo_ff[IDX_BITS-1:0];
         rden  = (lo_ff < count_ff);
      end
      if (cmd.shift) begin
         raddr = ptr_in[IDX_BITS-1:0];
         rden  = 1'b1;
      end
   end

   // Shift walks down from count-1: read ptr-1 while writing the entry read last
   // (the one at ptr) up to ptr+1.
   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; ptr_in = ptr_ff; phase_in = phase_ff;
      count_in = count_ff;
      if (cmd.start) begin
         lo_in = '0; hi_in = count_ff; phase_in = 1'b0;
         ptr_in = count_ff;
      end
      if (cmd.step) begin
         phase_in = ~phase_ff;
         if (phase_ff) begin
            if (is_lower) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
      end
      if (cmd.shift) ptr_in = ptr_ff - 1'b1;
      if (cmd.write) count_in = count_ff + 1'b1;
   end

   logic hit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; ptr_ff <= ptr_in;
      if (cmd.start) begin
         op_ff <= in_op; pool_ff <= in_pool; key_ff <= in_key; handle_ff <= in_handle;
      end
      if (rden) rdata_ff <= mem[raddr];
      if (cmd.rd) hit_ff <= (lo_ff < count_ff);
      if (cmd.shift && (ptr_ff != count_ff)) mem[wptr[IDX_BITS-1:0]] <= rdata_ff;
      if (cmd.write) mem[lo_ff[IDX_BITS-1:0]] <= {pool_ff, key_ff, handle_ff};
   end

   always_comb begin
      sts.search_done = (lo_ff >= hi_ff);
      sts.hit = hit_ff && (e_pool == pool_ff) && (e_key == key_ff);
      sts.full = (count_ff >= CNT_BITS'(CAPACITY));
      sts.shift_done = (ptr_ff == lo_ff);
      sts.pool_ok = (32'(pool_ff) < POOLS);
      sts.op = op_ff;
   end
endmodule
`default_nettype wire

>>> hw/rtl/skt_ctrl.sv
// Controller state machine sequencing search, shift and result.
`default_nettype none
module skt_ctrl import skt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   output logic      req_ready,
   output cmd_type   cmd,
   input  wire sts_type sts,
   input  wire logic rsp_free,
   output logic      rsp_load,
   output logic      rsp_found,
   output logic      rsp_use_handle,
   output logic      rsp_full
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SRCH  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_DEC   = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;
   state_type state_ff, state_in;
   logic found_ff, found_in, full_ff, full_in, useh_ff, useh_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_found = found_ff;
   assign rsp_full = full_ff;
   assign rsp_use_handle = useh_ff;

   always_comb begin
      state_in = state_ff; cmd = '0; rsp_load = 1'b0;
      found_in = found_ff; full_in = full_ff; useh_in = useh_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin cmd.start = 1'b1; state_in = S_SRCH; end
         S_SRCH: begin
            if (sts.search_done) begin cmd.rd = 1'b1; state_in = S_READ; end
            else cmd.step = 1'b1;
         end
         S_READ: state_in = S_DEC;
         S_DEC: begin
            found_in = 1'b0; full_in = 1'b0; useh_in = 1'b0;
            state_in = S_OUT;
            if (sts.pool_ok) begin
               if (sts.hit) begin
                  found_in = 1'b1; useh_in = (sts.op == OP_LOOKUP);
               end else if (sts.op == OP_INSERT) begin
                  if (sts.full) full_in = 1'b1;
                  else if (sts.shift_done) cmd.write = 1'b1;
                  else begin cmd.shift = 1'b1; state_in = S_SHIFT; end
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1; state_in = S_OUT;
         end
         S_OUT: if (rsp_free) begin rsp_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      found_ff <= found_in; full_ff <= full_in; useh_ff <= useh_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/sorted_key_table_insert_lookup.sv
// Top level: sorted (pool, key) table with insert and lookup.
// A search takes S binary search steps, S <= clog2(CAPACITY+1); an insert that
// moves entries up shifts one entry per cycle. One item is in work at a time,
// the next is taken in the cycle after the result is loaded. Reset empties the
// table by clearing the entry count; no clearing pass.
`default_nettype none
module sorted_key_table_insert_lookup import skt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: operation[0], pool[2:1], key[34:3], payload[66:35], zero fill to 72
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: found[0], result_payload[32:1], full_res[33], zero fill to 40
   output logic [39:0]      rsp_tdata
);
   cmd_type cmd;
   sts_type sts;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic rsp_load, rsp_found, rsp_useh, rsp_full;
   logic rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   skt_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .in_op(req_tdata[0]), .in_pool(req_tdata[2:1]),
      .in_key(req_tdata[34:3]), .in_handle(req_tdata[66:35]), .rd_handle
   );

   skt_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_ready(req_tready), .cmd, .sts,
      .rsp_free(!rsp_valid_ff || rsp_tready), .rsp_load,
      .rsp_found, .rsp_use_handle(rsp_useh), .rsp_full
   );

   // Hold the result until taken.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (rsp_load)
         rsp_data_ff <= {6'd0, rsp_full,
                         (rsp_useh ? rd_handle : {HANDLE_BITS{1'b0}}), rsp_found};
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule
`default_nettype wire

>>> hw/rtl/skt_checker.sv
// Port-level checker for the sorted key table.
`default_nettype none
module skt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp data moved");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tdata[33] && rsp_tvalid |-> !rsp_tdata[0] && rsp_tdata[32:1] == 32'd0)
      else $error("full with found");
   a_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("handle on miss");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("second item taken");
endmodule
bind sorted_key_table_insert_lookup skt_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire
